[design/kpt_pkg.sv]
// Shared types and constants of the key press, hold, release and click tracker.
package kpt_pkg;

	// Width of the configuration register and of the time field of a transaction.
	localparam int CFG_W      = 32;
	localparam int KEY_CODE_W = 8;
	localparam int NOW_W      = 32;

	// Click interval after reset: 0.2 s at a 1 ms tick.
	localparam logic [CFG_W-1:0] CLICK_INTERVAL_RST = 32'd200;

	// Command codes of an input transaction.
	typedef enum logic [1:0] {
		CMD_DOWN      = 2'd0,
		CMD_UP        = 2'd1,
		CMD_FRAME_END = 2'd2,
		CMD_READ      = 2'd3
	} cmd_t;

	// Per-key state codes.
	typedef enum logic [1:0] {
		ST_ABSENT = 2'd0,
		ST_DOWN   = 2'd1,
		ST_STAY   = 2'd2,
		ST_UP     = 2'd3
	} key_state_t;

	// One input transaction.
	typedef struct packed {
		cmd_t                  command;
		logic [KEY_CODE_W-1:0] key_code;
		logic [NOW_W-1:0]      now_time;
	} key_event_t;

	// One result transaction.
	typedef struct packed {
		key_state_t key_state;
		logic       clicked;
		logic       any_activity;
	} key_report_t;

	// One entry of the state memory.
	typedef struct packed {
		key_state_t state;
		logic       click;
	} entry_t;

endpackage

[design/kpt_chan_if.sv]
// Valid/ready channel interface used for all ports of the tracker.
interface kpt_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/kpt_mem.sv]
// Key table memories: entry state with click mark, and press time.
module kpt_mem #(
	parameter int NUM_KEYS  = 256,
	parameter int TIME_BITS = 32
) (
	input  logic                        clk,
	input  logic [$clog2(NUM_KEYS)-1:0] rd_addr,
	input  logic                        wr_en,
	input  logic                        wr_time_en,
	input  logic [$clog2(NUM_KEYS)-1:0] wr_addr,
	input  kpt_pkg::entry_t             wr_entry,
	input  logic [TIME_BITS-1:0]        wr_time,
	output kpt_pkg::entry_t             rd_entry,
	output logic [TIME_BITS-1:0]        rd_time
);

	kpt_pkg::entry_t      entry_mem [NUM_KEYS];
	logic [TIME_BITS-1:0] time_mem  [NUM_KEYS];

	// One write port and one registered read port per array.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_entry;
		end
		if (wr_time_en) begin
			time_mem[wr_addr] <= wr_time;
		end
		rd_entry <= entry_mem[rd_addr];
		rd_time  <= time_mem[rd_addr];
	end

endmodule

[design/kpt_ctrl.sv]
// Sequencer: clearing pass, read-modify-write of one key, and the frame-end sweep.
module kpt_ctrl #(
	parameter int NUM_KEYS  = 256,
	parameter int TIME_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	kpt_chan_if.sink                      key_event,
	kpt_chan_if.source                    key_report,
	input  logic [kpt_pkg::CFG_W-1:0]     click_interval,
	output logic [$clog2(NUM_KEYS)-1:0]   rd_addr,
	input  kpt_pkg::entry_t               rd_entry,
	input  logic [TIME_BITS-1:0]          rd_time,
	output logic                          wr_en,
	output logic                          wr_time_en,
	output logic [$clog2(NUM_KEYS)-1:0]   wr_addr,
	output kpt_pkg::entry_t               wr_entry,
	output logic [TIME_BITS-1:0]          wr_time
);

	localparam int KEY_W = $clog2(NUM_KEYS);
	localparam int CMP_W = (TIME_BITS > kpt_pkg::CFG_W) ? TIME_BITS : kpt_pkg::CFG_W;
	localparam logic [KEY_W-1:0] LAST_KEY = KEY_W'(NUM_KEYS - 1);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_UPDATE = 6'b000100,
		S_SWEEP  = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_REPORT = 6'b100000
	} state_t;

	state_t                         state_q;
	state_t                         state_d;
	logic [KEY_W-1:0]               cnt_q;
	logic                           sweep_vld_s1;
	logic [KEY_W-1:0]               sweep_addr_s1;
	kpt_pkg::cmd_t                  cmd_q;
	logic [kpt_pkg::KEY_CODE_W-1:0] key_q;
	logic [kpt_pkg::NOW_W-1:0]      now_q;
	logic                           key_ok_q;
	logic                           out_valid_q;
	kpt_pkg::key_report_t           report_q;

	logic                 in_take;
	logic                 out_free;
	logic                 key_ok_in;
	logic [TIME_BITS-1:0] held;
	logic                 click_hit;
	kpt_pkg::entry_t      upd_entry;
	logic                 upd_wr;
	logic                 upd_time_wr;
	kpt_pkg::entry_t      sweep_entry;
	kpt_pkg::key_report_t report_d;

	// Handshakes. A new transaction is taken only between items.
	assign key_event.ready  = (state_q == S_IDLE);
	assign in_take          = key_event.valid & key_event.ready;
	assign out_free         = ~out_valid_q | key_report.ready;
	assign key_report.valid = out_valid_q;
	assign key_report.data  = report_q;
	assign key_ok_in        = 32'(key_event.data.key_code) < 32'(NUM_KEYS);

	// Hold time modulo the time width, compared against the click interval.
	assign held      = TIME_BITS'(now_q) - rd_time;
	assign click_hit = CMP_W'(held) < CMP_W'(click_interval);

	// New entry for a key-down or key-up on the addressed key.
	always_comb begin
		upd_entry   = rd_entry;
		upd_wr      = 1'b0;
		upd_time_wr = 1'b0;
		if (key_ok_q) begin
			case (cmd_q)
				kpt_pkg::CMD_DOWN: begin
					if (rd_entry.state == kpt_pkg::ST_ABSENT) begin
						upd_entry.state = kpt_pkg::ST_DOWN;
						upd_wr          = 1'b1;
						upd_time_wr     = 1'b1;
					end
				end
				kpt_pkg::CMD_UP: begin
					if (rd_entry.state != kpt_pkg::ST_ABSENT) begin
						upd_entry.state = kpt_pkg::ST_UP;
						upd_entry.click = rd_entry.click | click_hit;
						upd_wr          = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result of the item: the addressed entry after the step.
	always_comb begin
		report_d = '0;
		if (key_ok_q) begin
			report_d.key_state    = upd_entry.state;
			report_d.clicked      = upd_entry.click;
			report_d.any_activity = (upd_entry.state != kpt_pkg::ST_ABSENT) | upd_entry.click;
		end
	end

	// Frame-end aging of one entry.
	always_comb begin
		sweep_entry.click = 1'b0;
		case (rd_entry.state)
			kpt_pkg::ST_UP:   sweep_entry.state = kpt_pkg::ST_ABSENT;
			kpt_pkg::ST_DOWN: sweep_entry.state = kpt_pkg::ST_STAY;
			default:          sweep_entry.state = rd_entry.state;
		endcase
	end

	// Read address: the incoming key while idle, the sweep counter, else the held key.
	always_comb begin
		if (state_q == S_IDLE) begin
			rd_addr = KEY_W'(key_event.data.key_code);
		end else if (state_q == S_SWEEP) begin
			rd_addr = cnt_q;
		end else begin
			rd_addr = KEY_W'(key_q);
		end
	end

	// Write port: clearing pass, sweep write-back, or the item's update.
	always_comb begin
		wr_en      = 1'b0;
		wr_time_en = 1'b0;
		wr_addr    = cnt_q;
		wr_entry   = '0;
		wr_time    = TIME_BITS'(now_q);
		if (state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (sweep_vld_s1) begin
			wr_en    = 1'b1;
			wr_addr  = sweep_addr_s1;
			wr_entry = sweep_entry;
		end else if ((state_q == S_UPDATE) && out_free) begin
			wr_en      = upd_wr;
			wr_time_en = upd_time_wr;
			wr_addr    = KEY_W'(key_q);
			wr_entry   = upd_entry;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (cnt_q == LAST_KEY) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_take) begin
					if (key_event.data.command == kpt_pkg::CMD_FRAME_END) state_d = S_SWEEP;
					else state_d = S_UPDATE;
				end
			end
			S_UPDATE: begin
				if (out_free) state_d = S_IDLE;
			end
			S_SWEEP: begin
				if (cnt_q == LAST_KEY) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = S_REPORT;
			S_REPORT: state_d = S_UPDATE;
			default: state_d = S_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			cnt_q        <= '0;
			sweep_vld_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			sweep_vld_s1 <= (state_q == S_SWEEP);
			if ((state_q == S_CLEAR) || (state_q == S_SWEEP)) begin
				cnt_q <= cnt_q + KEY_W'(1);
			end else if (in_take) begin
				cnt_q <= '0;
			end
			if ((state_q == S_UPDATE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (key_report.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and pipeline payload registers.
	always_ff @(posedge clk) begin
		sweep_addr_s1 <= cnt_q;
		if (in_take) begin
			cmd_q    <= key_event.data.command;
			key_q    <= key_event.data.key_code;
			now_q    <= key_event.data.now_time;
			key_ok_q <= key_ok_in;
		end
		if ((state_q == S_UPDATE) && out_free) begin
			report_q <= report_d;
		end
	end

endmodule

[design/key_press_hold_release_click_tracker.sv]
// Key down, key up, read: an item is accepted in the idle state and its result is registered in the update
// state; the next item is taken only back in idle, so no new item is taken before the last one is through.
// Frame end: a sweep over the state memory, one entry a cycle, then the drain, report and update states.
// Results wait in an output register; the update stalls only if that register is still full.
// After reset a clearing pass over all NUM_KEYS entries empties the state memory; no item is taken
// meanwhile, configuration writes are. The click interval resets to 200 ticks.
module key_press_hold_release_click_tracker #(
	parameter int NUM_KEYS  = 256,
	parameter int TIME_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	kpt_chan_if.sink   key_event,
	kpt_chan_if.source key_report,
	kpt_chan_if.sink   cfg
);

	localparam int KEY_W = $clog2(NUM_KEYS);

	logic [kpt_pkg::CFG_W-1:0] click_interval_q;
	logic [KEY_W-1:0]          rd_addr;
	logic [KEY_W-1:0]          wr_addr;
	logic                      wr_en;
	logic                      wr_time_en;
	kpt_pkg::entry_t           wr_entry;
	kpt_pkg::entry_t           rd_entry;
	logic [TIME_BITS-1:0]      wr_time;
	logic [TIME_BITS-1:0]      rd_time;

	// Configuration register, always writable.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_interval_q <= kpt_pkg::CLICK_INTERVAL_RST;
		end else if (cfg.valid) begin
			click_interval_q <= kpt_pkg::CFG_W'(cfg.data);
		end
	end

	// Sequencer.
	kpt_ctrl #(
		.NUM_KEYS  (NUM_KEYS),
		.TIME_BITS (TIME_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.key_event      (key_event),
		.key_report     (key_report),
		.click_interval (click_interval_q),
		.rd_addr        (rd_addr),
		.rd_entry       (rd_entry),
		.rd_time        (rd_time),
		.wr_en          (wr_en),
		.wr_time_en     (wr_time_en),
		.wr_addr        (wr_addr),
		.wr_entry       (wr_entry),
		.wr_time        (wr_time)
	);

	// Key table.
	kpt_mem #(
		.NUM_KEYS  (NUM_KEYS),
		.TIME_BITS (TIME_BITS)
	) u_mem (
		.clk        (clk),
		.rd_addr    (rd_addr),
		.wr_en      (wr_en),
		.wr_time_en (wr_time_en),
		.wr_addr    (wr_addr),
		.wr_entry   (wr_entry),
		.wr_time    (wr_time),
		.rd_entry   (rd_entry),
		.rd_time    (rd_time)
	);

endmodule

[dv/key_press_hold_release_click_tracker_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the key press, hold, release and click tracker.
module key_press_hold_release_click_tracker_tb;

	localparam int NUM_KEYS    = 256;
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int POOL_MAX    = 64;

	logic clk;
	logic arst_n;

	kpt_chan_if #(.payload_t(kpt_pkg::key_event_t))            key_event_bus ();
	kpt_chan_if #(.payload_t(kpt_pkg::key_report_t))           key_report_bus ();
	kpt_chan_if #(.payload_t(logic [kpt_pkg::CFG_W-1:0]))      cfg_bus ();

	key_press_hold_release_click_tracker #(
		.NUM_KEYS (NUM_KEYS),
		.TIME_BITS(32)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_event (key_event_bus),
		.key_report(key_report_bus),
		.cfg       (cfg_bus)
	);

	// Predicted copy of the key table and the click interval.
	kpt_pkg::key_state_t       key_table [NUM_KEYS];
	logic [kpt_pkg::NOW_W-1:0] press_stamp [NUM_KEYS];
	logic                      click_flag [NUM_KEYS];
	logic [kpt_pkg::CFG_W-1:0] click_interval_q;

	kpt_pkg::key_report_t      pending_reports [$];
	int                        mismatch_count;
	int                        cycle_count;
	bit                        idle_on;
	int                        report_hold_cycles;
	logic [kpt_pkg::NOW_W-1:0] clock_ticks;
	logic [7:0]                key_pool [POOL_MAX];

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run length guard.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Applies one transaction to the predicted table and returns the expected report.
	function automatic kpt_pkg::key_report_t predict_key_report(input kpt_pkg::key_event_t ev);
		kpt_pkg::key_report_t      rep;
		logic [kpt_pkg::NOW_W-1:0] held;
		int                        k;
		k = ev.key_code;
		case (ev.command)
			kpt_pkg::CMD_DOWN: begin
				if (k < NUM_KEYS && key_table[k] == kpt_pkg::ST_ABSENT) begin
					key_table[k]   = kpt_pkg::ST_DOWN;
					press_stamp[k] = ev.now_time;
				end
			end
			kpt_pkg::CMD_UP: begin
				if (k < NUM_KEYS && key_table[k] != kpt_pkg::ST_ABSENT) begin
					held = ev.now_time - press_stamp[k];
					if (held < click_interval_q)
						click_flag[k] = 1'b1;
					key_table[k] = kpt_pkg::ST_UP;
				end
			end
			kpt_pkg::CMD_FRAME_END: begin
				for (int i = 0; i < NUM_KEYS; i++) begin
					click_flag[i] = 1'b0;
					if (key_table[i] == kpt_pkg::ST_UP)
						key_table[i] = kpt_pkg::ST_ABSENT;
					else if (key_table[i] == kpt_pkg::ST_DOWN)
						key_table[i] = kpt_pkg::ST_STAY;
				end
			end
			default: ;
		endcase
		rep = '{key_state: kpt_pkg::ST_ABSENT, clicked: 1'b0, any_activity: 1'b0};
		if (k < NUM_KEYS) begin
			rep.key_state = key_table[k];
			rep.clicked   = click_flag[k];
		end
		rep.any_activity = (rep.key_state != kpt_pkg::ST_ABSENT) || rep.clicked;
		return rep;
	endfunction

	// Offers one key event and records its expected report once it is accepted.
	task automatic send_key_event(input kpt_pkg::cmd_t c, input logic [7:0] k,
			input logic [kpt_pkg::NOW_W-1:0] t);
		int                  gap;
		kpt_pkg::key_event_t ev;
		ev = '{command: c, key_code: k, now_time: t};
		gap = idle_on ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			key_event_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		key_event_bus.valid <= 1'b1;
		key_event_bus.data  <= ev;
		do @(posedge clk); while (!key_event_bus.ready);
		pending_reports.push_back(predict_key_report(ev));
	endtask

	// Stops offering and waits until every expected report has come back.
	task automatic wait_for_drain();
		key_event_bus.valid <= 1'b0;
		do @(posedge clk); while (pending_reports.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes the click interval while the tracker is idle.
	task automatic write_click_interval(input logic [kpt_pkg::CFG_W-1:0] value);
		wait_for_drain();
		cfg_bus.valid <= 1'b1;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		cfg_bus.valid <= 1'b0;
		click_interval_q = value;
	endtask

	// Report receiver: random stalls, a long hold-off on request, and the field checks.
	initial begin
		int                   stall;
		kpt_pkg::key_report_t got;
		kpt_pkg::key_report_t want;
		forever begin
			if (report_hold_cycles > 0) begin
				stall = report_hold_cycles;
				report_hold_cycles = 0;
			end else begin
				stall = idle_on ? $urandom_range(0, 15) : 0;
			end
			if (stall > 0) begin
				key_report_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			key_report_bus.ready <= 1'b1;
			do @(posedge clk); while (!key_report_bus.valid);
			got = key_report_bus.data;
			if (pending_reports.size() == 0) begin
				report_mismatch($sformatf("report with nothing expected: state %0d clicked %0d",
					got.key_state, got.clicked));
			end else begin
				want = pending_reports.pop_front();
				if (got.key_state !== want.key_state)
					report_mismatch($sformatf("key_state %0d, expected %0d",
						got.key_state, want.key_state));
				if (got.clicked !== want.clicked)
					report_mismatch($sformatf("clicked %0d, expected %0d",
						got.clicked, want.clicked));
				if (got.any_activity !== want.any_activity)
					report_mismatch($sformatf("any_activity %0d, expected %0d",
						got.any_activity, want.any_activity));
			end
		end
	end

	// Directed sequence at the reset click interval of 200 ticks.
	task automatic test_directed_reset_interval();
		send_key_event(kpt_pkg::CMD_READ, 8'h00, 32'd0);
		send_key_event(kpt_pkg::CMD_DOWN, 8'h00, 32'd0);
		// A second press of a held key leaves its press time alone.
		send_key_event(kpt_pkg::CMD_DOWN, 8'h00, 32'd50);
		send_key_event(kpt_pkg::CMD_UP, 8'h00, 32'd199);
		// Releasing an already released key repeats the click test; the mark stays.
		send_key_event(kpt_pkg::CMD_UP, 8'h00, 32'd400);
		send_key_event(kpt_pkg::CMD_READ, 8'h00, 32'd400);
		send_key_event(kpt_pkg::CMD_FRAME_END, 8'h00, 32'd401);
		// Release of a key that is not in the table changes nothing.
		send_key_event(kpt_pkg::CMD_UP, 8'h00, 32'd10);
		send_key_event(kpt_pkg::CMD_DOWN, 8'hFF, 32'hFFFF_FFF0);
		send_key_event(kpt_pkg::CMD_FRAME_END, 8'hFF, 32'hFFFF_FFF8);
		// Stay key released across the time wrap: a short hold, so a click.
		send_key_event(kpt_pkg::CMD_UP, 8'hFF, 32'h0000_0010);
		send_key_event(kpt_pkg::CMD_DOWN, 8'h80, 32'd1000);
		// A hold exactly equal to the interval is not a click.
		send_key_event(kpt_pkg::CMD_UP, 8'h80, 32'd1200);
		send_key_event(kpt_pkg::CMD_DOWN, 8'h80, 32'd1300);
		send_key_event(kpt_pkg::CMD_READ, 8'h80, 32'd1301);
		send_key_event(kpt_pkg::CMD_FRAME_END, 8'hC8, 32'd1302);
		send_key_event(kpt_pkg::CMD_READ, 8'hFF, 32'd1303);
		send_key_event(kpt_pkg::CMD_DOWN, 8'hAA, 32'hFFFF_FFFF);
		send_key_event(kpt_pkg::CMD_UP, 8'h55, 32'd0);
		send_key_event(kpt_pkg::CMD_READ, 8'hAA, 32'd1);
		send_key_event(kpt_pkg::CMD_FRAME_END, 8'h55, 32'd2);
		send_key_event(kpt_pkg::CMD_UP, 8'hAA, 32'h7FFF_FFFF);
		send_key_event(kpt_pkg::CMD_READ, 8'hAA, 32'h8000_0000);
		send_key_event(kpt_pkg::CMD_FRAME_END, 8'hAA, 32'h8000_0001);
	endtask

	// Click interval at both ends of its range.
	task automatic test_interval_extremes();
		write_click_interval('0);
		send_key_event(kpt_pkg::CMD_DOWN, 8'h03, 32'd5);
		send_key_event(kpt_pkg::CMD_UP, 8'h03, 32'd5);
		send_key_event(kpt_pkg::CMD_FRAME_END, 8'h03, 32'd6);
		write_click_interval('1);
		// The longest possible hold is still not below the largest interval.
		send_key_event(kpt_pkg::CMD_DOWN, 8'h04, 32'd1);
		send_key_event(kpt_pkg::CMD_UP, 8'h04, 32'd0);
		send_key_event(kpt_pkg::CMD_DOWN, 8'h05, 32'd100);
		send_key_event(kpt_pkg::CMD_UP, 8'h05, 32'd100);
		send_key_event(kpt_pkg::CMD_FRAME_END, 8'h05, 32'd101);
		send_key_event(kpt_pkg::CMD_READ, 8'h04, 32'd102);
	endtask

	// Random key traffic on a small pool of keys with a running time base.
	task automatic test_random_traffic(input logic [kpt_pkg::CFG_W-1:0] interval, input bit idle,
			input int n_items, input int pool_size);
		int            r;
		logic [7:0]    k;
		kpt_pkg::cmd_t c;
		write_click_interval(interval);
		idle_on = idle;
		for (int i = 0; i < pool_size; i++)
			key_pool[i] = 8'($urandom_range(0, 255));
		for (int n = 0; n < n_items; n++) begin
			r = $urandom_range(0, 99);
			if (r < 6) begin
				// Noise: any command, any key, any time.
				send_key_event(kpt_pkg::cmd_t'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)), $urandom);
			end else begin
				k = key_pool[$urandom_range(0, pool_size - 1)];
				if (r < 40)
					c = kpt_pkg::CMD_DOWN;
				else if (r < 75)
					c = kpt_pkg::CMD_UP;
				else if (r < 83)
					c = kpt_pkg::CMD_FRAME_END;
				else
					c = kpt_pkg::CMD_READ;
				// Mostly short steps so holds land on both sides of the interval.
				if ($urandom_range(0, 49) == 0)
					clock_ticks = $urandom;
				else if ($urandom_range(0, 3) == 0)
					clock_ticks = clock_ticks + $urandom_range(0, 400);
				else
					clock_ticks = clock_ticks + $urandom_range(0, 60);
				send_key_event(c, k, clock_ticks);
			end
		end
	endtask

	// Long receiver hold-off fills the tracker and stalls its input; a full drain, then releases and reads.
	task automatic test_backpressure();
		idle_on = 1'b0;
		wait_for_drain();
		report_hold_cycles = 400;
		for (int n = 0; n < 16; n++)
			send_key_event(n % 4 == 3 ? kpt_pkg::CMD_FRAME_END : kpt_pkg::CMD_DOWN,
				8'($urandom_range(0, 255)), $urandom);
		wait_for_drain();
		idle_on = 1'b1;
		for (int n = 0; n < 12; n++)
			send_key_event(n % 2 ? kpt_pkg::CMD_UP : kpt_pkg::CMD_READ,
				8'($urandom_range(0, 255)), $urandom);
	endtask

	// Stimulus and end of run.
	initial begin
		arst_n               <= 1'b0;
		key_event_bus.valid  <= 1'b0;
		key_event_bus.data   <= '0;
		cfg_bus.valid        <= 1'b0;
		cfg_bus.data         <= '0;
		cycle_count          = 0;
		mismatch_count       = 0;
		report_hold_cycles   = 0;
		idle_on              = 1'b1;
		clock_ticks          = $urandom;
		click_interval_q     = kpt_pkg::CLICK_INTERVAL_RST;
		for (int i = 0; i < NUM_KEYS; i++) begin
			key_table[i]   = kpt_pkg::ST_ABSENT;
			press_stamp[i] = '0;
			click_flag[i]  = 1'b0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_reset_interval();
		test_interval_extremes();
		test_random_traffic(32'd200, 1'b1, 340, 8);
		test_random_traffic('0, 1'b1, 300, 8);
		test_random_traffic('1, 1'b0, 300, 8);
		test_random_traffic($urandom_range(1, 2000), 1'b1, 340, 64);
		test_backpressure();
		test_random_traffic($urandom_range(20, 600), 1'b1, 340, 8);

		wait_for_drain();
		repeat (NUM_KEYS + 8) @(posedge clk);
		if (mismatch_count == 0 && pending_reports.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
design/kpt_pkg.sv
design/kpt_chan_if.sv
design/kpt_mem.sv
design/kpt_ctrl.sv
design/key_press_hold_release_click_tracker.sv
dv/key_press_hold_release_click_tracker_tb.sv
